// File: src/assert_macros.svh
// assertion macros included by the cipher rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// File: src/fbc16_pkg.sv
// types, constants and the round function of the 16-bit feistel cipher
package fbc16_pkg;

    localparam int HALF_W    = 8;
    localparam int BLOCK_W   = 16;
    localparam int SBOX_W    = 64;
    localparam int PBOX_W    = 24;
    localparam int ROUND_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;
    localparam int KEY_COUNT = 3;

    localparam logic [SBOX_W-1:0]  SBOX_RESET        = 64'hFEDC_BA98_7654_3210;
    localparam logic [PBOX_W-1:0]  PBOX_RESET        = 24'hFA_C688;
    localparam logic [HALF_W-1:0]  KEY_RESET         = 8'h00;
    localparam logic [ROUND_W-1:0] ROUND_COUNT_RESET = 2'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SBOX_TABLE  = 3'd0,
        CFG_PBOX_MAP    = 3'd1,
        CFG_KEY_ROUND1  = 3'd2,
        CFG_KEY_ROUND2  = 3'd3,
        CFG_KEY_ROUND3  = 3'd4,
        CFG_ROUND_COUNT = 3'd5
    } cfg_reg_t;

    // key xor, two nibble lookups, then output bit 7-i takes input bit 7-P[i]
    function automatic logic [HALF_W-1:0] round_f(
        input logic [HALF_W-1:0] half,
        input logic [HALF_W-1:0] key,
        input logic [SBOX_W-1:0] sbox,
        input logic [PBOX_W-1:0] pbox
    );
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        logic [2:0]        src;
        x = half ^ key;
        s = {sbox[{x[7:4], 2'b00} +: 4], sbox[{x[3:0], 2'b00} +: 4]};
        p = '0;
        for (int i = 0; i < HALF_W; i++) begin
            src = pbox[3*i +: 3];
            p[HALF_W-1-i] = s[3'd7 - src];
        end
        return p;
    endfunction

endpackage

// File: src/feistel_block_cipher_16bit.sv
// 16-bit feistel cipher: config registers, input register, rounds, result register
// Takes one block per cycle unless m_ready holds the output: the block
// is captured in an input register, the enabled rounds (each a key xor, two 4-bit
// s-box lookups, a bit permutation and a half swap) run as one combinational pass,
// and the result lands in the output register. The input register also fills while
// the output is held if it is empty, and a new block is accepted every cycle while
// m_ready stays high; s_ready follows m_ready combinationally through the two-entry
// pipeline. Round count 0 passes the block through, and counts above the smaller of
// MAX_ROUNDS and KEY_COUNT saturate to it. Mode 1 deciphers with the keys in
// reverse order. Configuration is taken every cycle on the cfg channel and must be
// written only while no block is in flight; writes to unused indexes are dropped.
module feistel_block_cipher_16bit
    import fbc16_pkg::*;
#(
    parameter int MAX_ROUNDS = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_mode,
    input  logic [BLOCK_W-1:0]    s_block_in,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BLOCK_W-1:0]    m_block_out
);

`include "assert_macros.svh"

    localparam int NUM_STAGES = (MAX_ROUNDS < KEY_COUNT) ? MAX_ROUNDS : KEY_COUNT;

    logic [SBOX_W-1:0]  sbox_table_reg;
    logic [PBOX_W-1:0]  pbox_map_reg;
    logic [HALF_W-1:0]  key_round1_reg;
    logic [HALF_W-1:0]  key_round2_reg;
    logic [HALF_W-1:0]  key_round3_reg;
    logic [ROUND_W-1:0] round_count_reg;

    logic               in_valid_reg;
    logic               in_mode_reg;
    logic [BLOCK_W-1:0] in_block_reg;
    logic               out_valid_reg;
    logic [BLOCK_W-1:0] out_block_reg;
    logic [BLOCK_W-1:0] out_block_next;

    logic               advance;
    logic [ROUND_W-1:0] rounds_eff;
    logic [ROUND_W-1:0] key_sel;
    logic [HALF_W-1:0]  key_cur;
    logic [HALF_W-1:0]  l_cur;
    logic [HALF_W-1:0]  r_cur;
    logic [HALF_W-1:0]  t_cur;

    assign cfg_ready   = 1'b1;
    assign advance     = !out_valid_reg || m_ready;
    assign s_ready     = !in_valid_reg || advance;
    assign m_valid     = out_valid_reg;
    assign m_block_out = out_block_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sbox_table_reg  <= SBOX_RESET;
            pbox_map_reg    <= PBOX_RESET;
            key_round1_reg  <= KEY_RESET;
            key_round2_reg  <= KEY_RESET;
            key_round3_reg  <= KEY_RESET;
            round_count_reg <= ROUND_COUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_SBOX_TABLE:  sbox_table_reg  <= cfg_data[SBOX_W-1:0];
                CFG_PBOX_MAP:    pbox_map_reg    <= cfg_data[PBOX_W-1:0];
                CFG_KEY_ROUND1:  key_round1_reg  <= cfg_data[HALF_W-1:0];
                CFG_KEY_ROUND2:  key_round2_reg  <= cfg_data[HALF_W-1:0];
                CFG_KEY_ROUND3:  key_round3_reg  <= cfg_data[HALF_W-1:0];
                CFG_ROUND_COUNT: round_count_reg <= cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    assign rounds_eff = (round_count_reg > ROUND_W'(NUM_STAGES)) ?
                        ROUND_W'(NUM_STAGES) : round_count_reg;

    always_comb begin
        l_cur   = in_block_reg[BLOCK_W-1:HALF_W];
        r_cur   = in_block_reg[HALF_W-1:0];
        t_cur   = '0;
        key_sel = '0;
        key_cur = '0;
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (ROUND_W'(i) < rounds_eff) begin
                // decrypt walks the keys from the last enabled round down
                key_sel = in_mode_reg ? (rounds_eff - ROUND_W'(i) - 2'd1) : ROUND_W'(i);
                case (key_sel)
                    2'd0:    key_cur = key_round1_reg;
                    2'd1:    key_cur = key_round2_reg;
                    default: key_cur = key_round3_reg;
                endcase
                if (!in_mode_reg) begin
                    t_cur = l_cur ^ round_f(r_cur, key_cur, sbox_table_reg, pbox_map_reg);
                    l_cur = r_cur;
                    r_cur = t_cur;
                end else begin
                    t_cur = r_cur ^ round_f(l_cur, key_cur, sbox_table_reg, pbox_map_reg);
                    r_cur = l_cur;
                    l_cur = t_cur;
                end
            end
        end
        out_block_next = {l_cur, r_cur};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_mode_reg  <= s_mode;
            in_block_reg <= s_block_in;
        end
        if (in_valid_reg && advance) begin
            out_block_reg <= out_block_next;
        end
    end

    `ASSERT_CLK(a_full_stall_blocks_input,
        (in_valid_reg && out_valid_reg && !m_ready) |-> !s_ready,
        "input accepted while both pipeline registers are held")
    `ASSERT_CLK(a_accept_fills_stage,
        (s_valid && s_ready) |=> in_valid_reg,
        "accepted word did not reach the input register")
    `ASSERT_CLK(a_stage_moves_out,
        (in_valid_reg && advance) |=> out_valid_reg,
        "input register advanced without producing a result")
    `ASSERT_CLK(a_zero_rounds_pass,
        (in_valid_reg && advance && rounds_eff == 2'd0) |=>
            (m_block_out == $past(in_block_reg)),
        "zero round count did not pass the block through")
    `ASSERT_ALWAYS(a_reset_clears_valid,
        !aresetn |=> (!in_valid_reg && !out_valid_reg),
        "pipeline valid set right after reset")

endmodule

// File: sim/tb_feistel_block_cipher_16bit.sv
// self-checking testbench for the 16-bit feistel cipher with random traffic and config sweeps
module tb_feistel_block_cipher_16bit
    import fbc16_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 20;
    localparam int MAX_ROUNDS   = 3;
    localparam int PIPE_LATENCY = 2;
    localparam int SETTLE       = 2 * PIPE_LATENCY;
    localparam int RANDOM_ITEMS = 1950;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 5000;

    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic               mode;
        logic [BLOCK_W-1:0] blk;
    } cipher_word_t;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  cfg_valid  = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index  = '0;
    logic [CFG_DATA_W-1:0] cfg_data   = '0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_mode     = MODE_ENCRYPT;
    logic [BLOCK_W-1:0]    s_block_in = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [BLOCK_W-1:0]    m_block_out;

    // mirror of the block's configuration
    logic [SBOX_W-1:0]  sbox_cur   = SBOX_RESET;
    logic [PBOX_W-1:0]  pbox_cur   = PBOX_RESET;
    logic [HALF_W-1:0]  key_cur [KEY_COUNT] = '{KEY_RESET, KEY_RESET, KEY_RESET};
    logic [ROUND_W-1:0] rounds_cur = ROUND_COUNT_RESET;

    cipher_word_t       pending_words[$];
    logic [BLOCK_W-1:0] expected_blocks[$];
    logic [BLOCK_W-1:0] want_block;
    int                 fail_count = 0;
    logic               in_fire    = 1'b0;

    // sender pacing
    cipher_word_t drv_word;
    logic         drv_valid;
    int           burst_left = 1;
    int           gap_left   = 0;

    // receiver pacing
    logic rdy_next;
    logic hold_trigger = 1'b0;
    logic hold_seen    = 1'b0;
    int   hold_left    = 0;
    int   rx_cycle     = 0;
    int   rx_style     = 0;

    int idle_cycles = 0;

    feistel_block_cipher_16bit #(
        .MAX_ROUNDS(MAX_ROUNDS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_block_in (s_block_in),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_block_out(m_block_out)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    function automatic logic [HALF_W-1:0] round_mix(
        input logic [HALF_W-1:0] half,
        input logic [HALF_W-1:0] key
    );
        logic [HALF_W-1:0] x;
        logic [HALF_W-1:0] s;
        logic [HALF_W-1:0] p;
        logic [2:0]        src;
        x = half ^ key;
        s = {sbox_cur[int'(x[7:4]) * 4 +: 4], sbox_cur[int'(x[3:0]) * 4 +: 4]};
        p = '0;
        for (int i = 0; i < HALF_W; i++) begin
            src = pbox_cur[3 * i +: 3];
            p[HALF_W - 1 - i] = s[HALF_W - 1 - int'(src)];
        end
        return p;
    endfunction

    function automatic logic [BLOCK_W-1:0] cipher_predict(
        input logic               mode,
        input logic [BLOCK_W-1:0] blk
    );
        logic [HALF_W-1:0] lh;
        logic [HALF_W-1:0] rh;
        logic [HALF_W-1:0] t;
        int                n;
        lh = blk[BLOCK_W-1:HALF_W];
        rh = blk[HALF_W-1:0];
        n  = int'(rounds_cur);
        if (n > MAX_ROUNDS) n = MAX_ROUNDS;
        for (int i = 0; i < n; i++) begin
            if (mode == MODE_ENCRYPT) begin
                t  = lh ^ round_mix(rh, key_cur[i]);
                lh = rh;
                rh = t;
            end else begin
                t  = rh ^ round_mix(lh, key_cur[n - 1 - i]);
                rh = lh;
                lh = t;
            end
        end
        return {lh, rh};
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random permutation of 0..count-1 packed at the given entry width
    function automatic logic [63:0] shuffled(input int count, input int width);
        int          a[16];
        int          j;
        int          t;
        logic [63:0] w;
        for (int i = 0; i < count; i++) a[i] = i;
        for (int i = count - 1; i > 0; i--) begin
            j    = $urandom_range(0, i);
            t    = a[i];
            a[i] = a[j];
            a[j] = t;
        end
        w = '0;
        for (int i = 0; i < count; i++) w |= 64'(a[i]) << (i * width);
        return w;
    endfunction

    function automatic logic [63:0] pick_key();
        case ($urandom_range(0, 3))
            0: return 64'h0;
            1: return {56'h0, 8'hFF};
            2: return '1;
            default: return rand64();
        endcase
    endfunction

    function automatic logic [BLOCK_W-1:0] pick_block();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return BLOCK_W'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_SBOX_TABLE:  sbox_cur   = data;
            CFG_PBOX_MAP:    pbox_cur   = data[PBOX_W-1:0];
            CFG_KEY_ROUND1:  key_cur[0] = data[HALF_W-1:0];
            CFG_KEY_ROUND2:  key_cur[1] = data[HALF_W-1:0];
            CFG_KEY_ROUND3:  key_cur[2] = data[HALF_W-1:0];
            CFG_ROUND_COUNT: rounds_cur = data[ROUND_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_all(
        input logic [63:0] sbox,
        input logic [63:0] pbox,
        input logic [63:0] k1,
        input logic [63:0] k2,
        input logic [63:0] k3,
        input logic [63:0] rc
    );
        write_reg(CFG_SBOX_TABLE, sbox);
        write_reg(CFG_PBOX_MAP, pbox);
        write_reg(CFG_KEY_ROUND1, k1);
        write_reg(CFG_KEY_ROUND2, k2);
        write_reg(CFG_KEY_ROUND3, k3);
        write_reg(CFG_ROUND_COUNT, rc);
        if ($urandom_range(0, 3) == 0)
            write_reg(($urandom_range(0, 1) == 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI, rand64());
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_word(input logic mode, input logic [BLOCK_W-1:0] blk);
        pending_words.push_back(cipher_word_t'{mode: mode, blk: blk});
    endtask

    // wait until every queued word has gone through and the pipeline is empty
    task automatic drain();
        @(posedge aclk);
        while (pending_words.size() != 0 || s_valid || expected_blocks.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // input driver
    always @(negedge aclk) begin
        if (!s_valid || in_fire) begin
            drv_valid = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() != 0) begin
                drv_word   = pending_words.pop_front();
                drv_valid  = 1'b1;
                s_mode     <= drv_word.mode;
                s_block_in <= drv_word.blk;
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
            s_valid <= drv_valid;
        end
    end

    // result receiver
    always @(negedge aclk) begin
        rx_cycle++;
        if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            rdy_next = 1'b0;
        end else begin
            case (rx_style)
                0: rdy_next = 1'b1;
                1: rdy_next = ($urandom_range(0, 1) == 0);
                2: rdy_next = ($urandom_range(0, 3) == 0);
                default: rdy_next = ($urandom_range(0, 7) != 0);
            endcase
        end
        m_ready <= rdy_next;
    end

    // monitor and scoreboard
    always @(posedge aclk) begin
        in_fire <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_blocks.size() == 0) begin
                    $display("%0t: unexpected word, expected none, actual block_out %h",
                             $time, m_block_out);
                    fail_count++;
                end else begin
                    want_block = expected_blocks.pop_front();
                    if (m_block_out !== want_block) begin
                        $display("%0t: block_out mismatch, expected %h, actual %h",
                                 $time, want_block, m_block_out);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready)
                expected_blocks.push_back(cipher_predict(s_mode, s_block_in));
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("feistel_block_cipher_16bit test failed");
            $finish;
        end
    end

    initial begin
        int total;
        int n_items;
        int phase;
        logic [63:0] sbox_w;
        logic [63:0] pbox_w;

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: identity boxes, zero keys, three rounds
        push_word(MODE_ENCRYPT, 16'h0000);
        push_word(MODE_DECRYPT, 16'hFFFF);
        push_word(MODE_ENCRYPT, 16'hFF00);
        push_word(MODE_DECRYPT, 16'h00FF);
        push_word(MODE_ENCRYPT, 16'h8001);
        drain();

        program_all(shuffled(16, 4), shuffled(8, 3), 64'h5A, 64'hC3, 64'h17, 64'h3);
        write_reg(CFG_UNUSED_LO, '1);
        write_reg(CFG_UNUSED_HI, '0);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        push_word(MODE_ENCRYPT, 16'h0000);
        push_word(MODE_DECRYPT, 16'h0000);
        push_word(MODE_ENCRYPT, 16'hFFFF);
        push_word(MODE_DECRYPT, 16'hFFFF);
        push_word(MODE_ENCRYPT, 16'h1234);
        push_word(MODE_DECRYPT, 16'hA55A);
        drain();

        // zero round count passes the word through
        program_all(rand64(), rand64(), rand64(), rand64(), rand64(), 64'h0);
        push_word(MODE_ENCRYPT, 16'hBEEF);
        push_word(MODE_DECRYPT, 16'h0F0F);
        push_word(MODE_ENCRYPT, 16'hFFFF);
        drain();

        // all-ones sbox, every permutation source the same bit, all-ones keys, one round
        program_all('1, 64'h0, '1, '1, '1, 64'h1);
        push_word(MODE_ENCRYPT, 16'h0001);
        push_word(MODE_DECRYPT, 16'h8000);
        push_word(MODE_ENCRYPT, 16'h7FFE);
        drain();

        // zero sbox, reversed permutation, two rounds
        program_all(64'h0, 64'h053977, 64'h0, 64'hFF, 64'h0, 64'h2);
        push_word(MODE_ENCRYPT, 16'hC001);
        push_word(MODE_DECRYPT, 16'h3FFE);
        drain();

        total = 0;
        phase = 0;
        while (total < RANDOM_ITEMS) begin
            case ($urandom_range(0, 4))
                0: sbox_w = SBOX_RESET;
                1: sbox_w = shuffled(16, 4);
                2: sbox_w = 64'h0;
                3: sbox_w = '1;
                default: sbox_w = rand64();
            endcase
            case ($urandom_range(0, 4))
                0: pbox_w = PBOX_RESET;
                1: pbox_w = shuffled(8, 3);
                2: pbox_w = 64'h053977;
                3: pbox_w = {40'h0, {8{3'($urandom_range(0, 7))}}};
                default: pbox_w = rand64();
            endcase
            program_all(sbox_w, pbox_w, pick_key(), pick_key(), pick_key(), rand64());
            n_items = $urandom_range(20, 110);
            for (int i = 0; i < n_items; i++)
                push_word(1'($urandom_range(0, 1)), pick_block());
            // stall the receiver while the sender keeps offering
            if (phase == 2 || phase == 9) begin
                @(negedge aclk);
                hold_trigger <= ~hold_trigger;
            end
            drain();
            total += n_items;
            phase++;
        end

        drain();
        if (expected_blocks.size() != 0)
            $display("%0t: %0d expected words never arrived", $time, expected_blocks.size());
        if (fail_count == 0 && expected_blocks.size() == 0) begin
            $display("feistel_block_cipher_16bit test passed");
        end else begin
            $display("feistel_block_cipher_16bit test failed");
        end
        $finish;
    end

endmodule
